FILE: sv/hex_axial_world_convert_assert.svh
// Assertion macros shared by the hex/world converter.
`ifndef HEX_AXIAL_WORLD_CONVERT_ASSERT_SVH
`define HEX_AXIAL_WORLD_CONVERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HAWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hex_axial_world_convert: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HAWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hex_axial_world_convert: next-cycle check failed");

`endif

FILE: sv/hawc_pkg.sv
package hawc_pkg;

	// Default width of the axial coordinates.
	localparam int HAWC_HEX_COORD_BITS = 16;
	// Fraction bits of the world format; the fractional axial values carry 28 more.
	localparam int HAWC_WORLD_FRAC_BITS = 16;
	localparam int HAWC_HEX_FB = HAWC_WORLD_FRAC_BITS + 28;
	// Integer bits left in a 64-bit fractional axial value.
	localparam int HAWC_HEX_INT_W = 64 - HAWC_HEX_FB;

	// Number of pipeline stages, the last being the output register.
	localparam int HAWC_STAGES = 7;

	// Layout constants in Q2.30, rounded to nearest.
	localparam logic [31:0] C_SQRT3_HALF = 32'd929887697;
	localparam logic [31:0] C_THREE_HALF = 32'd1610612736;
	localparam logic [31:0] C_SQRT3_THIRD = 32'd619925131;
	localparam logic [31:0] C_TWO_THIRD = 32'd715827883;
	localparam logic [31:0] C_ONE_THIRD = 32'd357913941;

	// Register indexes of the configuration port.
	localparam logic [1:0] CFG_ORIENTATION = 2'd0;
	localparam logic [1:0] CFG_HEX_SIZE = 2'd1;
	localparam logic [1:0] CFG_INV_HEX_SIZE = 2'd2;

	// Register reset values.
	localparam logic HAWC_ORIENT_RST = 1'b0;
	localparam logic [31:0] HAWC_HEX_SIZE_RST = 32'd65536;
	localparam logic [31:0] HAWC_INV_SIZE_RST = 32'd1073741824;

	// Layout and conversion codes.
	localparam logic ORIENT_POINTY = 1'b0;
	localparam logic ORIENT_FLAT = 1'b1;
	localparam logic MODE_HEX_TO_WORLD = 1'b0;
	localparam logic MODE_WORLD_TO_HEX = 1'b1;

	// Stage load enables and stage valid bits of the pipeline.
	typedef struct packed {
		logic [HAWC_STAGES-1:0] en;
		logic [HAWC_STAGES-1:0] vld;
	} hawc_pipe_t;

endpackage

FILE: sv/hawc_ctrl.sv
module hawc_ctrl import hawc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_mode,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_mode,
	output hawc_pipe_t pipe
);

	logic [HAWC_STAGES-1:0] vld_s;
	logic [HAWC_STAGES-1:0] mode_s;
	logic [HAWC_STAGES-1:0] en;

	// A stage can load when it is empty or when the stage after it loads too.
	always_comb begin
		en[HAWC_STAGES-1] = !vld_s[HAWC_STAGES-1] || out_ready;
		for (int k = HAWC_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < HAWC_STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mode_s[0] <= in_mode;
		end
		for (int k = 1; k < HAWC_STAGES; k++) begin
			if (en[k]) begin
				mode_s[k] <= mode_s[k-1];
			end
		end
	end

	assign in_ready = en[0];
	assign out_mode = mode_s[HAWC_STAGES-1];
	assign pipe.en = en;
	assign pipe.vld = vld_s;

endmodule

FILE: sv/hawc_h2w.sv
module hawc_h2w import hawc_pkg::*; #(
	parameter int HEX_COORD_BITS = HAWC_HEX_COORD_BITS
) (
	input  logic                             clk,
	input  logic [HAWC_STAGES-1:0]           en,
	input  logic                             orientation,
	input  logic [31:0]                      hex_size,
	input  logic signed [HEX_COORD_BITS-1:0] q_in,
	input  logic signed [HEX_COORD_BITS-1:0] r_in,
	output logic signed [31:0]               world_x,
	output logic signed [31:0]               world_y,
	output logic                             sat
);

	localparam int TW = HEX_COORD_BITS + 2;
	localparam int KW = (TW > 34) ? TW : 34;

	// Magnitude of a signed term, clamped to 2^32.
	function automatic logic [32:0] mag_clamp(input logic signed [TW-1:0] t);
		logic [TW-1:0] m;
		logic [KW-1:0] mk;
		m = t[TW-1] ? $unsigned(-t) : $unsigned(t);
		mk = KW'(m);
		if (mk > KW'(34'h1_0000_0000)) begin
			return 33'h1_0000_0000;
		end
		return mk[32:0];
	endfunction

	// Round the Q.30 product, saturate and apply the sign. Returns {sat, value}.
	function automatic logic [32:0] finish(input logic [63:29] pc, input logic big,
	                                       input logic neg);
		logic [33:0] v;
		logic [33:0] lim;
		logic [31:0] w;
		logic        s;
		v = pc[63:30] + {33'b0, pc[29]};
		lim = neg ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
		s = big || (v > lim);
		w = s ? lim[31:0] : v[31:0];
		return {s, neg ? (~w + 32'd1) : w};
	endfunction

	// Stage 1: layout terms in sign and magnitude.
	logic signed [TW-1:0] q_e, r_e, tx_d, ty_d;
	logic                 neg_x_s1, neg_y_s1;
	logic [32:0]          mag_x_s1, mag_y_s1;

	always_comb begin
		q_e = TW'(q_in);
		r_e = TW'(r_in);
		if (orientation == ORIENT_POINTY) begin
			tx_d = (q_e <<< 1) + r_e;
			ty_d = r_e;
		end else begin
			tx_d = q_e;
			ty_d = q_e + (r_e <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_x_s1 <= tx_d[TW-1];
			neg_y_s1 <= ty_d[TW-1];
			mag_x_s1 <= mag_clamp(tx_d);
			mag_y_s1 <= mag_clamp(ty_d);
		end
	end

	// Stage 2: scale by the hex size.
	logic [64:0] prod_x, prod_y;
	logic [32:0] p_x_s2, p_y_s2;
	logic        big_x_s2, big_y_s2, neg_x_s2, neg_y_s2;

	assign prod_x = hex_size * mag_x_s1;
	assign prod_y = hex_size * mag_y_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_x_s2 <= prod_x[32:0];
			p_y_s2 <= prod_y[32:0];
			big_x_s2 <= |prod_x[64:33];
			big_y_s2 <= |prod_y[64:33];
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
		end
	end

	// Stage 3: multiply by the layout constant.
	logic [31:0] c_x, c_y;
	logic [63:0] pc_x, pc_y;
	logic [63:29] pc_x_s3, pc_y_s3;
	logic        big_x_s3, big_y_s3, neg_x_s3, neg_y_s3;

	assign c_x = (orientation == ORIENT_POINTY) ? C_SQRT3_HALF : C_THREE_HALF;
	assign c_y = (orientation == ORIENT_POINTY) ? C_THREE_HALF : C_SQRT3_HALF;
	assign pc_x = p_x_s2 * c_x;
	assign pc_y = p_y_s2 * c_y;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pc_x_s3 <= pc_x[63:29];
			pc_y_s3 <= pc_y[63:29];
			big_x_s3 <= big_x_s2;
			big_y_s3 <= big_y_s2;
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
		end
	end

	// Stage 4: round and saturate; stages 5 to 7 align with the other path.
	logic [32:0] fin_x, fin_y;
	logic signed [31:0] wx_s4, wy_s4, wx_s5, wy_s5, wx_s6, wy_s6, wx_s7, wy_s7;
	logic        sat_s4, sat_s5, sat_s6, sat_s7;

	assign fin_x = finish(pc_x_s3, big_x_s3, neg_x_s3);
	assign fin_y = finish(pc_y_s3, big_y_s3, neg_y_s3);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			wx_s4 <= fin_x[31:0];
			wy_s4 <= fin_y[31:0];
			sat_s4 <= fin_x[32] || fin_y[32];
		end
		if (en[4]) begin
			wx_s5 <= wx_s4;
			wy_s5 <= wy_s4;
			sat_s5 <= sat_s4;
		end
		if (en[5]) begin
			wx_s6 <= wx_s5;
			wy_s6 <= wy_s5;
			sat_s6 <= sat_s5;
		end
		if (en[6]) begin
			wx_s7 <= wx_s6;
			wy_s7 <= wy_s6;
			sat_s7 <= sat_s6;
		end
	end

	assign world_x = wx_s7;
	assign world_y = wy_s7;
	assign sat = sat_s7;

endmodule

FILE: sv/hawc_w2h.sv
module hawc_w2h import hawc_pkg::*; #(
	parameter int HEX_COORD_BITS = HAWC_HEX_COORD_BITS
) (
	input  logic                             clk,
	input  logic [HAWC_STAGES-1:0]           en,
	input  logic                             orientation,
	input  logic [31:0]                      inv_hex_size,
	input  logic signed [31:0]               world_x_in,
	input  logic signed [31:0]               world_y_in,
	output logic signed [HEX_COORD_BITS-1:0] hex_q,
	output logic signed [HEX_COORD_BITS-1:0] hex_r,
	output logic signed [HEX_COORD_BITS-1:0] hex_s,
	output logic                             sat
);

	localparam int FB = HAWC_HEX_FB;
	localparam int WQ = HAWC_HEX_INT_W;
	localparam int VW = WQ + 1;
	localparam int CW = (VW > HEX_COORD_BITS) ? VW : HEX_COORD_BITS;
	localparam logic [63:0] HALF_FB = 64'd1 << (FB - 1);

	// Value plus half, less one when negative: an arithmetic shift of this
	// rounds half away from zero.
	function automatic logic [63:0] pre_round(input logic [63:0] v, input logic [63:0] half);
		return v + half - {63'b0, v[63]};
	endfunction

	// Rounding error magnitude from the low bits of a pre-rounded value.
	function automatic logic [FB:0] round_err(input logic [FB-1:0] lo, input logic neg);
		logic [FB:0] e;
		e = {1'b0, lo} - {2'b01, {(FB-1){1'b0}}} + {{FB{1'b0}}, neg};
		return e[FB] ? (~e + 1'b1) : e;
	endfunction

	// Clip to the coordinate range. Returns {clipped, value}.
	function automatic logic [HEX_COORD_BITS:0] clip(input logic signed [VW-1:0] v);
		logic signed [CW-1:0] ve, hi, lo;
		ve = CW'(v);
		hi = $signed({{(CW-HEX_COORD_BITS+1){1'b0}}, {(HEX_COORD_BITS-1){1'b1}}});
		lo = $signed({{(CW-HEX_COORD_BITS+1){1'b1}}, {(HEX_COORD_BITS-1){1'b0}}});
		if (ve > hi) begin
			return {1'b1, hi[HEX_COORD_BITS-1:0]};
		end
		if (ve < lo) begin
			return {1'b1, lo[HEX_COORD_BITS-1:0]};
		end
		return {1'b0, ve[HEX_COORD_BITS-1:0]};
	endfunction

	// Stage 1: constant times world products. aq = k1*x - k2*y, ar = k3*y - k4*x.
	logic signed [31:0] k1, k2, k3, k4;
	logic signed [63:0] p1_d, p2_d, p3_d, p4_d;
	logic signed [63:0] p1_s1, p2_s1, p3_s1, p4_s1;

	always_comb begin
		if (orientation == ORIENT_POINTY) begin
			k1 = C_SQRT3_THIRD;
			k2 = C_ONE_THIRD;
			k3 = C_TWO_THIRD;
			k4 = '0;
		end else begin
			k1 = C_TWO_THIRD;
			k2 = '0;
			k3 = C_SQRT3_THIRD;
			k4 = C_ONE_THIRD;
		end
		p1_d = k1 * world_x_in;
		p2_d = k2 * world_y_in;
		p3_d = k3 * world_y_in;
		p4_d = k4 * world_x_in;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p1_s1 <= p1_d;
			p2_s1 <= p2_d;
			p3_s1 <= p3_d;
			p4_s1 <= p4_d;
		end
	end

	// Stage 2: sums.
	logic signed [63:0] aq_s2, ar_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			aq_s2 <= p1_s1 - p2_s1;
			ar_s2 <= p3_s1 - p4_s1;
		end
	end

	// Stage 3: drop 32 bits with rounding.
	logic [63:0]        aq_w, ar_w;
	logic signed [31:0] aq_s3, ar_s3;

	assign aq_w = pre_round(aq_s2, 64'h8000_0000);
	assign ar_w = pre_round(ar_s2, 64'h8000_0000);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			aq_s3 <= aq_w[63:32];
			ar_s3 <= ar_w[63:32];
		end
	end

	// Stage 4: scale by the reciprocal of the hex size.
	logic signed [32:0] inv_x;
	logic signed [63:0] qf_d, rf_d, qf_s4, rf_s4;

	assign inv_x = {1'b0, inv_hex_size};
	assign qf_d = aq_s3 * inv_x;
	assign rf_d = ar_s3 * inv_x;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			qf_s4 <= qf_d;
			rf_s4 <= rf_d;
		end
	end

	// Stage 5: third cube component and pre-rounded q and r.
	logic [63:0] wq_s5, wr_s5;
	logic signed [63:0] sf_s5;
	logic        nq_s5, nr_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sf_s5 <= -qf_s4 - rf_s4;
			wq_s5 <= pre_round(qf_s4, HALF_FB);
			wr_s5 <= pre_round(rf_s4, HALF_FB);
			nq_s5 <= qf_s4[63];
			nr_s5 <= rf_s4[63];
		end
	end

	// Stage 6: rounded components and their rounding errors.
	logic [63:0]          ws;
	logic signed [WQ-1:0] qi_s6, ri_s6, si_s6;
	logic [FB:0]          dq_s6, dr_s6, ds_s6;

	assign ws = pre_round(sf_s5, HALF_FB);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			qi_s6 <= wq_s5[63:FB];
			ri_s6 <= wr_s5[63:FB];
			si_s6 <= ws[63:FB];
			dq_s6 <= round_err(wq_s5[FB-1:0], nq_s5);
			dr_s6 <= round_err(wr_s5[FB-1:0], nr_s5);
			ds_s6 <= round_err(ws[FB-1:0], sf_s5[63]);
		end
	end

	// Stage 7: rebuild the worst component from the other two, then clip.
	logic signed [VW-1:0]     qe, re, se;
	logic [HEX_COORD_BITS:0]  cq, cr, cs;
	logic signed [HEX_COORD_BITS-1:0] hq_s7, hr_s7, hs_s7;
	logic                     sat_s7;

	always_comb begin
		qe = VW'(qi_s6);
		re = VW'(ri_s6);
		se = VW'(si_s6);
		if (dq_s6 > dr_s6 && dq_s6 > ds_s6) begin
			qe = -re - se;
		end else if (dr_s6 > ds_s6) begin
			re = -qe - se;
		end else begin
			se = -qe - re;
		end
		cq = clip(qe);
		cr = clip(re);
		cs = clip(se);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			hq_s7 <= cq[HEX_COORD_BITS-1:0];
			hr_s7 <= cr[HEX_COORD_BITS-1:0];
			hs_s7 <= cs[HEX_COORD_BITS-1:0];
			sat_s7 <= cq[HEX_COORD_BITS] || cr[HEX_COORD_BITS] || cs[HEX_COORD_BITS];
		end
	end

	assign hex_q = hq_s7;
	assign hex_r = hr_s7;
	assign hex_s = hs_s7;
	assign sat = sat_s7;

endmodule

FILE: sv/hex_axial_world_convert.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  request: mode, axial q and r, world x and y
// m_*       out        m_tvalid / m_tready  result: world x and y, hex q, r, s, saturated
// cfg_*     in         cfg_valid / cfg_ready  register index and write data
//
// Requests are taken one per clock, back to back. A request taken at a rising edge
// moves through the stages in order to the seventh and last, and its result can leave
// from there when m_tready is high. Reset clears the stage valid bits and loads the
// register reset values; both ready outputs rise at the first edge after release.
// A result stall holds the last stage while empty upstream stages keep loading, so the
// input stalls only once all seven are full; no request is lost or repeated.
`include "hex_axial_world_convert_assert.svh"

module hex_axial_world_convert import hawc_pkg::*; #(
	parameter int HEX_COORD_BITS = HAWC_HEX_COORD_BITS
) (
	input  logic clk,
	input  logic arst_n,

	// Request channel.
	input  logic s_tvalid,
	output logic s_tready,
	// q_in, r_in (HEX_COORD_BITS each), world_x_in, world_y_in (32 each), zero fill
	input  logic [((2*HEX_COORD_BITS+64+7)/8)*8-1:0] s_tdata,
	// mode
	input  logic s_tuser,

	// Result channel.
	output logic m_tvalid,
	input  logic m_tready,
	// world_x_out, world_y_out (32 each), hex_q, hex_r, hex_s (HEX_COORD_BITS each),
	// zero fill
	output logic [((3*HEX_COORD_BITS+64+7)/8)*8-1:0] m_tdata,
	// saturated
	output logic m_tuser,

	// Register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int HCB = HEX_COORD_BITS;
	localparam int OUT_W = ((3*HEX_COORD_BITS+64+7)/8)*8;

	// Both channels stay closed while reset is asserted and open at the first
	// edge after it is released.
	logic run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	// Configuration registers. They are writable whenever the block is out of
	// reset; a write lands in the next cycle and affects every stage that reads
	// it, so registers are meant to be written only while no request is in flight.
	logic        orientation_q;
	logic [31:0] hex_size_q;
	logic [31:0] inv_hex_size_q;

	assign cfg_ready = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q <= HAWC_ORIENT_RST;
			hex_size_q <= HAWC_HEX_SIZE_RST;
			inv_hex_size_q <= HAWC_INV_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIENTATION: begin
					orientation_q <= cfg_data[0];
				end
				CFG_HEX_SIZE: begin
					hex_size_q <= cfg_data;
				end
				CFG_INV_HEX_SIZE: begin
					inv_hex_size_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Unpack the request.
	logic signed [HCB-1:0] q_in, r_in;
	logic signed [31:0]    world_x_in, world_y_in;

	assign q_in = s_tdata[HCB-1:0];
	assign r_in = s_tdata[2*HCB-1:HCB];
	assign world_x_in = s_tdata[2*HCB+31:2*HCB];
	assign world_y_in = s_tdata[2*HCB+63:2*HCB+32];

	// Stage valid bits and load enables. Both datapaths run on every request;
	// the mode carried beside the valid bits picks the result at the end.
	hawc_pipe_t pipe;
	logic       out_mode;
	logic       pipe_ready;

	hawc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid && run_q),
		.in_mode  (s_tuser),
		.in_ready (pipe_ready),
		.out_ready(m_tready),
		.out_mode (out_mode),
		.pipe     (pipe)
	);

	assign s_tready = pipe_ready && run_q;

	// Hex to world: layout term, size product, constant product, rounding.
	logic signed [31:0] wx, wy;
	logic               w_sat;

	hawc_h2w #(
		.HEX_COORD_BITS(HEX_COORD_BITS)
	) u_h2w (
		.clk        (clk),
		.en         (pipe.en),
		.orientation(orientation_q),
		.hex_size   (hex_size_q),
		.q_in       (q_in),
		.r_in       (r_in),
		.world_x    (wx),
		.world_y    (wy),
		.sat        (w_sat)
	);

	// World to hex: constant products, sums, rounding, reciprocal product,
	// cube rounding and the rebuild of the component with the largest error.
	logic signed [HCB-1:0] hq, hr, hs;
	logic                  h_sat;

	hawc_w2h #(
		.HEX_COORD_BITS(HEX_COORD_BITS)
	) u_w2h (
		.clk         (clk),
		.en          (pipe.en),
		.orientation (orientation_q),
		.inv_hex_size(inv_hex_size_q),
		.world_x_in  (world_x_in),
		.world_y_in  (world_y_in),
		.hex_q       (hq),
		.hex_r       (hr),
		.hex_s       (hs),
		.sat         (h_sat)
	);

	// Fields of the mode that was not requested read as zero.
	logic signed [31:0]    world_x_out, world_y_out;
	logic signed [HCB-1:0] hex_q, hex_r, hex_s;
	logic                  is_w2h;

	assign is_w2h = (out_mode == MODE_WORLD_TO_HEX);
	assign world_x_out = is_w2h ? '0 : wx;
	assign world_y_out = is_w2h ? '0 : wy;
	assign hex_q = is_w2h ? hq : '0;
	assign hex_r = is_w2h ? hr : '0;
	assign hex_s = is_w2h ? hs : '0;

	assign m_tvalid = pipe.vld[HAWC_STAGES-1];
	assign m_tdata = OUT_W'({hex_s, hex_r, hex_q, world_y_out, world_x_out});
	assign m_tuser = is_w2h ? h_sat : w_sat;

	// A rounded cube that was not clipped always sums to zero.
	logic [HCB-1:0] cube_sum;
	assign cube_sum = hex_q + hex_r + hex_s;

	localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN = 32'h8000_0000;

	// A clipped world result sits at one end of the signed range.
	logic w_extreme;
	assign w_extreme = (wx == W_MAX) || (wx == W_MIN) || (wy == W_MAX) || (wy == W_MIN);

	// Out of reset, the input side only stalls when every stage is full and the output waits.
	`HAWC_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, run_q && !s_tready, m_tvalid && !m_tready)
	`HAWC_ASSERT_IMP(a_cube_sum_zero, clk, arst_n, m_tvalid && is_w2h && !h_sat, cube_sum == '0)
	`HAWC_ASSERT_IMP(a_world_sat_extreme, clk, arst_n, m_tvalid && !is_w2h && w_sat, w_extreme)
	`HAWC_ASSERT_NEXT(a_mid_stage_holds, clk, arst_n, pipe.vld[3] && !pipe.en[3], pipe.vld[3])

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Bench for the hex/world coordinate converter.
//
// Requests are queued by the main initial block and presented on the slave
// stream by a driver that runs on the falling clock edge. A monitor samples
// both streams on the rising edge. Every accepted request is run through a
// local model of the converter, and the answer joins the queue of pending
// coordinates. Each accepted result is compared field by field with the
// oldest pending entry. Layout, hex size and reciprocal are rewritten only
// while nothing is in flight.
module tb;
	import hawc_pkg::*;

	localparam int HB = HAWC_HEX_COORD_BITS;
	localparam int S_W = ((2*HB+64+7)/8)*8;
	localparam int M_W = ((3*HB+64+7)/8)*8;
	// The fractional axial values carry this many fraction bits.
	localparam int FRAC_HEX = HAWC_WORLD_FRAC_BITS + 28;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LEN = 80;
	localparam int PHASES = 8;
	localparam int PHASE_REQS = 55;

	// Layout constants, Q2.30.
	localparam logic [31:0] K_SQRT3_HALF = 32'd929887697;
	localparam logic [31:0] K_THREE_HALF = 32'd1610612736;
	localparam longint K_SQRT3_THIRD = 64'sd619925131;
	localparam longint K_TWO_THIRD = 64'sd715827883;
	localparam longint K_ONE_THIRD = 64'sd357913941;

	typedef struct packed {
		logic          mode;
		logic [HB-1:0] q;
		logic [HB-1:0] r;
		logic [31:0]   x;
		logic [31:0]   y;
	} point_req_t;

	typedef struct packed {
		logic [31:0]   wx;
		logic [31:0]   wy;
		logic [HB-1:0] hq;
		logic [HB-1:0] hr;
		logic [HB-1:0] hs;
		logic          sat;
	} coord_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata = '0;
	logic           s_tuser = 1'b0;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic           m_tuser;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [1:0]     cfg_index = CFG_ORIENTATION;
	logic [31:0]    cfg_data = '0;

	// Our copy of the register file, kept in step with every write.
	logic        lay_flat = HAWC_ORIENT_RST;
	logic [31:0] size_q16 = HAWC_HEX_SIZE_RST;
	logic [31:0] inv_q230 = HAWC_INV_SIZE_RST;

	point_req_t point_feed[$];
	coord_res_t coord_due[$];
	point_req_t on_bus = '0;

	int reqs_queued = 0;
	int reqs_taken = 0;
	int results_seen = 0;
	int w2h_count = 0;
	int sat_count = 0;
	int reg_writes = 0;
	int fault_count = 0;
	int cycle_count = 0;

	// Idling controls, set per phase by the main sequence.
	int feed_gap_max = 19;
	int sink_gap_max = 19;
	int feed_wait = 0;
	bit feed_gap_set = 1'b0;
	int sink_wait = 0;
	int hold_asks = 0;
	int holds_served = 0;
	int hold_left = 0;

	// Handshakes seen at the last rising edge, for the falling-edge drivers.
	logic req_fired = 1'b0;
	logic res_fired = 1'b0;

	hex_axial_world_convert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Divide by 2^sh, rounding half away from zero.
	function automatic longint round_away(longint v, int sh);
		logic [63:0] m;
		m = (v < 0) ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// size * t * k / 2^30 rounded half away from zero and clipped to 32 bits.
	// The top bit of the return value says whether the clip was taken.
	function automatic logic [32:0] scale_world(logic [31:0] sz, longint t, logic [31:0] k);
		logic         neg;
		logic [63:0]  m;
		logic [63:0]  lim;
		logic [127:0] p;
		logic [127:0] v;
		logic         ovf;
		neg = (t < 0);
		m = neg ? 64'(-t) : 64'(t);
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (m > 64'h1_0000_0000)
			m = 64'h1_0000_0000;
		p = sz * m;
		ovf = (p >= 128'h2_0000_0000);
		v = ovf ? 128'd0 : ((p * k + (128'd1 << 29)) >> 30);
		if (ovf || v > lim) begin
			v = lim;
			ovf = 1'b1;
		end
		return {ovf, neg ? (~v[31:0] + 32'd1) : v[31:0]};
	endfunction

	function automatic longint clip_hex(longint v);
		longint hi;
		hi = (longint'(1) << (HB - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// What the converter must return for one request under the current registers.
	function automatic coord_res_t convert_point(point_req_t p);
		coord_res_t o;
		longint     q, r, x, y, aq, ar, qf, rf, sf, qi, ri, si, dq, dr, ds, unit;
		longint     qc, rc, sc;
		logic [32:0] ex, ey;
		o = '0;
		unit = longint'(1) << FRAC_HEX;
		if (p.mode == MODE_HEX_TO_WORLD) begin
			q = longint'($signed(p.q));
			r = longint'($signed(p.r));
			if (lay_flat == ORIENT_POINTY) begin
				ex = scale_world(size_q16, 2 * q + r, K_SQRT3_HALF);
				ey = scale_world(size_q16, r, K_THREE_HALF);
			end else begin
				ex = scale_world(size_q16, q, K_THREE_HALF);
				ey = scale_world(size_q16, q + 2 * r, K_SQRT3_HALF);
			end
			o.wx = ex[31:0];
			o.wy = ey[31:0];
			o.sat = ex[32] | ey[32];
		end else begin
			x = longint'($signed(p.x));
			y = longint'($signed(p.y));
			if (lay_flat == ORIENT_POINTY) begin
				aq = K_SQRT3_THIRD * x - K_ONE_THIRD * y;
				ar = K_TWO_THIRD * y;
			end else begin
				aq = K_TWO_THIRD * x;
				ar = K_SQRT3_THIRD * y - K_ONE_THIRD * x;
			end
			qf = round_away(aq, 32) * longint'(inv_q230);
			rf = round_away(ar, 32) * longint'(inv_q230);
			sf = -qf - rf;
			qi = round_away(qf, FRAC_HEX);
			ri = round_away(rf, FRAC_HEX);
			si = round_away(sf, FRAC_HEX);
			dq = mag(qi * unit - qf);
			dr = mag(ri * unit - rf);
			ds = mag(si * unit - sf);
			// The component that moved most in rounding is rebuilt from the other two,
			// so that q + r + s stays zero. Ties go to the later one: r over q, s over both.
			if (dq > dr && dq > ds)
				qi = -ri - si;
			else if (dr > ds)
				ri = -qi - si;
			else
				si = -qi - ri;
			qc = clip_hex(qi);
			rc = clip_hex(ri);
			sc = clip_hex(si);
			o.hq = qc[HB-1:0];
			o.hr = rc[HB-1:0];
			o.hs = sc[HB-1:0];
			o.sat = (qc != qi) || (rc != ri) || (sc != si);
		end
		return o;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
		fault_count++;
	endtask

	// Request driver. A new request goes out once the previous one has been
	// taken and its drawn idle time has run out.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_fired)) begin
			if (!feed_gap_set) begin
				feed_wait = $urandom_range(0, feed_gap_max);
				feed_gap_set = 1'b1;
			end
			if (feed_wait > 0) begin
				feed_wait--;
				s_tvalid <= 1'b0;
			end else if (point_feed.size() != 0) begin
				on_bus = point_feed.pop_front();
				s_tdata <= {on_bus.y, on_bus.x, on_bus.r, on_bus.q};
				s_tuser <= on_bus.mode;
				s_tvalid <= 1'b1;
				feed_gap_set = 1'b0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result-side ready. A long hold, when one is asked for, is counted here;
	// otherwise every taken result is followed by a drawn number of stalled cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left == 0 && hold_asks != holds_served) begin
				holds_served++;
				hold_left = HOLD_LEN;
			end
			if (res_fired)
				sink_wait = $urandom_range(0, sink_gap_max);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on every accepted request, checks every accepted result.
	always @(posedge clk) begin
		coord_res_t want;
		if (arst_n) begin
			req_fired <= s_tvalid && s_tready;
			res_fired <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				coord_due.insert(coord_due.size(), convert_point(on_bus));
				reqs_taken++;
				if (on_bus.mode == MODE_WORLD_TO_HEX)
					w2h_count++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (coord_due.size() == 0) begin
					flag_mismatch("unrequested result", m_tdata[31:0], 32'd0);
				end else begin
					want = coord_due.pop_front();
					if (m_tdata[31:0] !== want.wx)
						flag_mismatch("world_x_out", m_tdata[31:0], want.wx);
					if (m_tdata[63:32] !== want.wy)
						flag_mismatch("world_y_out", m_tdata[63:32], want.wy);
					if (m_tdata[64 +: HB] !== want.hq)
						flag_mismatch("hex_q", m_tdata[64 +: HB], want.hq);
					if (m_tdata[64+HB +: HB] !== want.hr)
						flag_mismatch("hex_r", m_tdata[64+HB +: HB], want.hr);
					if (m_tdata[64+2*HB +: HB] !== want.hs)
						flag_mismatch("hex_s", m_tdata[64+2*HB +: HB], want.hs);
					if (m_tuser !== want.sat)
						flag_mismatch("saturated", m_tuser, want.sat);
					if (want.sat)
						sat_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, coord_due.size() + reqs_queued - reqs_taken);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic queue_req(point_req_t p);
		point_feed.insert(point_feed.size(), p);
		reqs_queued++;
	endtask

	function automatic point_req_t hex_req(int q, int r);
		point_req_t p;
		p = '0;
		p.mode = MODE_HEX_TO_WORLD;
		p.q = q[HB-1:0];
		p.r = r[HB-1:0];
		return p;
	endfunction

	function automatic point_req_t world_req(logic [31:0] x, logic [31:0] y);
		point_req_t p;
		p = '0;
		p.mode = MODE_WORLD_TO_HEX;
		p.x = x;
		p.y = y;
		return p;
	endfunction

	// A world value within span of the origin.
	function automatic logic [31:0] near_world(longint span);
		longint v;
		v = longint'($urandom_range(0, 32'(2 * span))) - span;
		return v[31:0];
	endfunction

	// Random request. Mostly points at a sensible distance for the current hex
	// size, with a share of raw values so that every input bit toggles.
	function automatic point_req_t rand_req();
		point_req_t p;
		longint     span;
		span = longint'(size_q16) * $urandom_range(1, 40);
		if (span > 64'sh7FFF_FFFF)
			span = 64'sh7FFF_FFFF;
		p.mode = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0) begin
			p.q = HB'($urandom);
			p.r = HB'($urandom);
		end else begin
			p.q = HB'($urandom_range(0, 400) - 200);
			p.r = HB'($urandom_range(0, 400) - 200);
		end
		if ($urandom_range(0, 3) == 0) begin
			p.x = $urandom;
			p.y = $urandom;
		end else begin
			p.x = near_world(span);
			p.y = near_world(span);
		end
		return p;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ORIENTATION:  lay_flat = val[0];
			CFG_HEX_SIZE:     size_q16 = val;
			CFG_INV_HEX_SIZE: inv_q230 = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Let the pipeline run dry: every request taken, every result checked, and an
	// idle wait on top so that nothing is left inside the stages.
	task automatic settle();
		while (reqs_queued != reqs_taken || coord_due.size() != 0)
			@(negedge clk);
		repeat (HAWC_STAGES + 3) @(negedge clk);
	endtask

	initial begin
		int          ph;
		int          n;
		logic [31:0] sz;
		logic [63:0] recip;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset registers: pointy layout, unit size. Coordinate extremes in both modes.
		queue_req(hex_req(0, 0));
		queue_req(hex_req(1, -1));
		queue_req(hex_req(32767, 32767));
		queue_req(hex_req(-32768, -32768));
		queue_req(hex_req(32767, -32768));
		queue_req(world_req(32'd0, 32'd0));
		queue_req(world_req(32'h7FFF_FFFF, 32'h8000_0000));
		queue_req(world_req(32'h8000_0000, 32'h7FFF_FFFF));
		queue_req(world_req(32'd98304, 32'd56756));
		queue_req(world_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		settle();

		// Flat layout with the largest size and reciprocal: world and hex results
		// both run out of range and must clip, except for the origin request.
		write_reg(CFG_ORIENTATION, 32'(ORIENT_FLAT));
		write_reg(CFG_HEX_SIZE, 32'hFFFF_FFFF);
		write_reg(CFG_INV_HEX_SIZE, 32'hFFFF_FFFF);
		queue_req(hex_req(1, 0));
		queue_req(hex_req(0, 0));
		queue_req(hex_req(-32768, 32767));
		queue_req(world_req(32'h7FFF_FFFF, 32'h7FFF_FFFF));
		queue_req(world_req(32'd0, 32'h8000_0000));
		settle();

		// Zero size and zero reciprocal collapse everything to the origin.
		write_reg(CFG_ORIENTATION, 32'(ORIENT_POINTY));
		write_reg(CFG_HEX_SIZE, 32'd0);
		write_reg(CFG_INV_HEX_SIZE, 32'd0);
		queue_req(hex_req(32767, -5));
		queue_req(world_req(32'd12345678, -32'sd7654321));
		queue_req(world_req(32'h8000_0000, 32'h8000_0000));
		settle();

		// Smallest nonzero size and reciprocal.
		write_reg(CFG_HEX_SIZE, 32'd1);
		write_reg(CFG_INV_HEX_SIZE, 32'd1);
		queue_req(hex_req(-32768, 32767));
		queue_req(world_req(32'h7FFF_FFFF, 32'h8000_0000));
		settle();

		// Random phases, each with its own layout, size and reciprocal. Draining
		// between phases also gives the pause in which the sender waits for every
		// outstanding result.
		for (ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: sz = $urandom_range(1, 64) << 16;
				1: sz = $urandom_range(1, 32'hFFFF_FFFF);
				2: sz = $urandom_range(1, 32'h0010_0000);
				default: sz = 32'h0001_0000 >> $urandom_range(0, 15);
			endcase
			recip = (64'h4000_0000_0000 + (sz >> 1)) / sz;
			if (recip > 64'hFFFF_FFFF)
				recip = 64'hFFFF_FFFF;
			write_reg(CFG_ORIENTATION, $urandom_range(0, 1));
			write_reg(CFG_HEX_SIZE, sz);
			write_reg(CFG_INV_HEX_SIZE, ($urandom_range(0, 4) == 0) ? $urandom : recip[31:0]);

			feed_gap_max = 19;
			sink_gap_max = 19;
			if (ph == 2) begin
				// The result side holds off while requests keep coming, so the
				// pipeline fills and has to push back on its input.
				feed_gap_max = 0;
				hold_asks++;
			end else if (ph == 5) begin
				feed_gap_max = 0;
				sink_gap_max = 0;
			end
			for (n = 0; n < PHASE_REQS; n++)
				queue_req(rand_req());
			settle();
		end

		$display("Checked %0d results for %0d requests (%0d world to hex), %0d saturated.",
			results_seen, reqs_taken, w2h_count, sat_count);
		$display("Made %0d register writes over %0d settings; %0d mismatches.",
			reg_writes, PHASES + 3, fault_count);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
